// File: rtl/assert_macros.svh
// assertion macros used by the port-level checker in zte_checker.sv
// expects clk and rst_n to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ZTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// checked on every edge, reset included
`define ZTE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// File: rtl/zte_pkg.sv
// types, constants and helpers for the z-character text encoder
// no dependencies; imported by every module of the block
package zte_pkg;

  localparam int ALPHABET_ENTRIES = 78;
  localparam int CHAR_CODES       = 256;
  localparam int SET_SIZE         = 26;
  localparam int TAB_AW           = $clog2(CHAR_CODES);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-3:0] REG_PERM_SHIFT = '0;

  localparam logic [4:0]  ZC_SPACE     = 5'd0;
  localparam logic [4:0]  ZC_TEMP_BASE = 5'd3;
  localparam logic [4:0]  ZC_SHIFT2    = 5'd5;
  localparam logic [4:0]  ZC_ESCAPE    = 5'd6;
  localparam logic [6:0]  ZC_CODE_BASE = 7'd6;
  localparam logic [7:0]  CHAR_SPACE   = 8'h20;
  localparam logic [1:0]  PCNT_FULL    = 2'd3;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_LOAD   = 3'd1,
    CMD_START  = 3'd2,
    CMD_ENCODE = 3'd3,
    CMD_FINISH = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    Q_START  = 2'd0,
    Q_ENCODE = 2'd1,
    Q_FINISH = 2'd2
  } qop_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] character;
    logic [7:0] next_character;
    logic [6:0] alphabet_position;
    logic [4:0] required_length;
  } in_t;

  typedef struct packed {
    logic [15:0] packed_word;
    logic        last_word;
  } out_t;

  // classified item handed from front to back
  typedef struct packed {
    qop_e       op;
    logic [7:0] ch;
    logic [4:0] rlen;
    logic [6:0] entry;    // set<<5 | code, zero when unmapped
    logic       lock_ok;  // next byte is mapped and non-zero
    logic [1:0] nset;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // table entry for an alphabet slot, slot assumed below ALPHABET_ENTRIES
  function automatic logic [6:0] slot_entry(input logic [6:0] pos);
    logic [1:0] s;
    logic [6:0] c;
    if (pos >= 7'(2 * SET_SIZE)) begin
      s = 2'd2;
      c = pos - 7'(2 * SET_SIZE) + ZC_CODE_BASE;
    end else if (pos >= 7'(SET_SIZE)) begin
      s = 2'd1;
      c = pos - 7'(SET_SIZE) + ZC_CODE_BASE;
    end else begin
      s = 2'd0;
      c = pos + ZC_CODE_BASE;
    end
    return {s, c[4:0]};
  endfunction

endpackage

// File: rtl/zte_fifo.sv
// short queue of classified items between front and back
// depends on zte_pkg
module zte_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  zte_pkg::qent_t  push_data,
  input  logic            pop,
  output zte_pkg::qent_t  pop_data,
  output zte_pkg::q_stat_t stat
);
  import zte_pkg::*;

  qent_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   cnt_r;

  function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
    return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (cnt_r == (Q_AW + 1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// File: rtl/zte_front.sv
// front end: takes input beats, owns the alphabet table, classifies items
// depends on zte_pkg; feeds zte_fifo
module zte_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  zte_pkg::in_t   in_data,
  output logic           in_stall,
  input  logic           q_full,
  output logic           push,
  output zte_pkg::qent_t push_data
);
  import zte_pkg::*;

  logic [6:0]            tab_mem [CHAR_CODES];
  logic [CHAR_CODES-1:0] vld_r;

  logic        s1_valid_r;
  qop_e        s1_op_r;
  logic [7:0]  s1_ch_r;
  logic [7:0]  s1_nxt_r;
  logic [4:0]  s1_rlen_r;
  logic [6:0]  rd_a_r;
  logic [6:0]  rd_b_r;
  logic        va_r;
  logic        vb_r;

  cmd_e              cmd;
  logic              accept;
  logic              queued;
  qop_e              op;
  logic              a_in_range;
  logic              b_in_range;
  logic [TAB_AW-1:0] ia;
  logic [TAB_AW-1:0] ib;
  logic              load_ok;
  logic              clear;
  logic [6:0]        entry_a;

  assign cmd        = cmd_e'(in_data.cmd);
  assign in_stall   = s1_valid_r && q_full;
  assign accept     = in_valid && !in_stall;
  assign a_in_range = (9'(in_data.character) < 9'(CHAR_CODES));
  assign b_in_range = (9'(in_data.next_character) < 9'(CHAR_CODES));
  assign ia         = in_data.character[TAB_AW-1:0];
  assign ib         = in_data.next_character[TAB_AW-1:0];
  assign clear      = accept && (cmd == CMD_CLEAR);
  assign load_ok    = accept && (cmd == CMD_LOAD) && (in_data.character != '0) &&
                      a_in_range && (in_data.alphabet_position < 7'(ALPHABET_ENTRIES));

  always_comb begin
    queued = 1'b1;
    op     = Q_START;
    unique case (cmd)
      CMD_START:  op = Q_START;
      CMD_ENCODE: op = Q_ENCODE;
      CMD_FINISH: op = Q_FINISH;
      default:    queued = 1'b0;
    endcase
  end

  // table with two registered read ports, one per byte of the beat
  always_ff @(posedge clk) begin
    if (load_ok) begin
      tab_mem[ia] <= slot_entry(in_data.alphabet_position);
    end
    if (accept) begin
      rd_a_r <= tab_mem[ia];
      rd_b_r <= tab_mem[ib];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clear) begin
      vld_r <= '0;
    end else if (load_ok) begin
      vld_r[ia] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= op;
      s1_ch_r   <= in_data.character;
      s1_nxt_r  <= in_data.next_character;
      s1_rlen_r <= in_data.required_length;
      va_r      <= vld_r[ia] && a_in_range;
      vb_r      <= vld_r[ib] && b_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= queued;
    end else if (push) begin
      s1_valid_r <= 1'b0;
    end
  end

  assign push    = s1_valid_r && !q_full;
  assign entry_a = va_r ? rd_a_r : '0;

  always_comb begin
    push_data.op      = s1_op_r;
    push_data.ch      = s1_ch_r;
    push_data.rlen    = s1_rlen_r;
    push_data.entry   = entry_a;
    push_data.lock_ok = (s1_nxt_r != '0) && vb_r && (rd_b_r[4:0] != '0);
    push_data.nset    = rd_b_r[6:5];
  end

endmodule

// File: rtl/zte_back.sv
// back end: expands items into z-characters, packs words, holds the output beat
// depends on zte_pkg; fed by zte_fifo
module zte_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             perm_shift,
  input  zte_pkg::qent_t   q_data,
  input  zte_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  output zte_pkg::out_t    out_data,
  input  logic             out_stall
);
  import zte_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ZCHARS = 4'b0010,
    ST_PAD    = 4'b0100,
    ST_LAST   = 4'b1000
  } st_t;

  typedef struct packed {
    logic [4:0][4:0] zs;
    logic [2:0]      len;
    logic [1:0]      set;
  } zlist_t;

  st_t             st_r, st_nxt;
  logic [4:0][4:0] list_r, list_nxt;
  logic [2:0]      len_r, len_nxt;
  logic [2:0]      idx_r, idx_nxt;
  logic [1:0]      set_r, set_nxt;
  logic [14:0]     pword_r, pword_nxt;
  logic [1:0]      pcnt_r, pcnt_nxt;
  logic [7:0]      zcnt_r, zcnt_nxt;
  logic [4:0]      lim_r, lim_nxt;
  logic            out_valid_r;
  out_t            out_data_r;

  zlist_t      bl;
  logic        out_free;
  logic        at_limit;
  logic        step_ok;
  logic        do_put;
  logic [4:0]  z;
  logic        emit;
  out_t        emit_data;
  logic [14:0] fin_w;

  // z-character sequence for one byte, plus the set left behind
  function automatic zlist_t build_list(input qent_t e, input logic [1:0] cur,
                                        input logic ps);
    zlist_t     r;
    logic [2:0] n;
    logic [1:0] s;
    logic [4:0] code;
    logic [1:0] cset;
    r.zs = '0;
    n    = '0;
    s    = cur;
    code = e.entry[4:0];
    cset = e.entry[6:5];
    if (e.ch == CHAR_SPACE) begin
      r.zs[n] = ZC_SPACE;
      n = n + 1'b1;
    end else if (code == '0) begin
      // unmapped byte goes out as shifts to set 2 where needed, then escape and two halves
      if (s == 2'd1) begin
        r.zs[n] = ZC_SHIFT2;
        n = n + 1'b1;
        s = 2'd0;
      end
      if (s == 2'd0) begin
        r.zs[n] = ZC_SHIFT2;
        n = n + 1'b1;
      end
      r.zs[n] = ZC_ESCAPE;
      n = n + 1'b1;
      r.zs[n] = {2'b00, e.ch[7:5]};
      n = n + 1'b1;
      r.zs[n] = e.ch[4:0];
      n = n + 1'b1;
    end else begin
      if ((cset != s) && (s != 2'd0)) begin
        // shift back towards set 0 from a locked set
        r.zs[n] = ZC_TEMP_BASE + 5'd3 - {3'b000, s};
        n = n + 1'b1;
        s = 2'd0;
      end
      if (cset != s) begin
        r.zs[n] = ZC_TEMP_BASE + {3'b000, cset};
        n = n + 1'b1;
        if (ps && e.lock_ok && (e.nset == cset)) begin
          r.zs[n] = ZC_TEMP_BASE + {3'b000, cset};
          n = n + 1'b1;
          s = cset;
        end
      end
      r.zs[n] = code;
      n = n + 1'b1;
    end
    r.len = n;
    r.set = s;
    return r;
  endfunction

  assign bl       = build_list(q_data, set_r, perm_shift);
  assign out_free = !out_valid_r || !out_stall;
  assign at_limit = (lim_r != '0) && (zcnt_r >= {3'b000, lim_r});
  assign step_ok  = at_limit || (pcnt_r != PCNT_FULL) || out_free;

  // final word padded with shifts to three z-characters
  always_comb begin
    case (pcnt_r)
      2'd0:    fin_w = {ZC_SHIFT2, ZC_SHIFT2, ZC_SHIFT2};
      2'd1:    fin_w = {pword_r[4:0], ZC_SHIFT2, ZC_SHIFT2};
      2'd2:    fin_w = {pword_r[9:0], ZC_SHIFT2};
      default: fin_w = pword_r;
    endcase
  end

  always_comb begin
    st_nxt    = st_r;
    list_nxt  = list_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    set_nxt   = set_r;
    pword_nxt = pword_r;
    pcnt_nxt  = pcnt_r;
    zcnt_nxt  = zcnt_r;
    lim_nxt   = lim_r;
    pop       = 1'b0;
    do_put    = 1'b0;
    z         = ZC_SPACE;
    emit      = 1'b0;
    emit_data = '0;

    unique case (st_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          case (q_data.op)
            Q_START: begin
              lim_nxt   = q_data.rlen;
              zcnt_nxt  = '0;
              pword_nxt = '0;
              pcnt_nxt  = '0;
              set_nxt   = '0;
            end
            Q_ENCODE: begin
              list_nxt = bl.zs;
              len_nxt  = bl.len;
              set_nxt  = bl.set;
              idx_nxt  = '0;
              st_nxt   = ST_ZCHARS;
            end
            Q_FINISH: st_nxt = ST_PAD;
            default: ;
          endcase
        end
      end
      ST_ZCHARS: begin
        z = list_r[idx_r];
        if (step_ok) begin
          do_put = 1'b1;
          if (idx_r == len_r - 3'd1) st_nxt = ST_IDLE;
          else idx_nxt = idx_r + 3'd1;
        end
      end
      ST_PAD: begin
        z = ZC_SHIFT2;
        if ((lim_r == '0) || at_limit) st_nxt = ST_LAST;
        else if (step_ok) do_put = 1'b1;
      end
      ST_LAST: begin
        if (out_free) begin
          emit                  = 1'b1;
          emit_data.packed_word = {1'b1, fin_w};
          emit_data.last_word   = 1'b1;
          pword_nxt             = '0;
          pcnt_nxt              = '0;
          zcnt_nxt              = '0;
          set_nxt               = '0;
          st_nxt                = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    // pack one z-character; a full word leaves only when another arrives
    if (do_put && !at_limit) begin
      if (pcnt_r == PCNT_FULL) begin
        emit                  = 1'b1;
        emit_data.packed_word = {1'b0, pword_r};
        emit_data.last_word   = 1'b0;
        pword_nxt             = {10'b0, z};
        pcnt_nxt              = 2'd1;
      end else begin
        pword_nxt = {pword_r[9:0], z};
        pcnt_nxt  = pcnt_r + 2'd1;
      end
      if (zcnt_r != 8'hff) zcnt_nxt = zcnt_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      set_r   <= '0;
      pword_r <= '0;
      pcnt_r  <= '0;
      zcnt_r  <= '0;
      lim_r   <= '0;
      idx_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      set_r   <= set_nxt;
      pword_r <= pword_nxt;
      pcnt_r  <= pcnt_nxt;
      zcnt_r  <= zcnt_nxt;
      lim_r   <= lim_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    list_r <= list_nxt;
    len_r  <= len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data_r <= emit_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/zchar_text_encoder.sv
// path: an accepted beat is registered in the front stage, then pushed into the back end queue
// throughput: front takes one beat a cycle while the four-entry queue has room;
// back takes one item at a time: a start, an encode of 1..5 z-characters, or a finish with
// padding and the final word; the packer takes one z-character per cycle unless the output stalls
// reset: synchronous, clears control state and the alphabet valid bits, no clearing pass
// top level: config register, front end, queue and back end; depends on zte_pkg
module zchar_text_encoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  zte_pkg::in_t               in_data,
  output logic                       in_stall,
  output logic                       out_valid,
  output zte_pkg::out_t              out_data,
  input  logic                       out_stall,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [zte_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import zte_pkg::*;

  logic    perm_shift_r;
  logic    push;
  qent_t   push_data;
  logic    pop;
  qent_t   q_data;
  q_stat_t q_stat;
  logic    reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_AW-1:2] == REG_PERM_SHIFT);
  assign prdata  = reg_hit ? {31'b0, perm_shift_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_shift_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      perm_shift_r <= pwdata[0];
    end
  end

  zte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .q_full    (q_stat.full),
    .push      (push),
    .push_data (push_data)
  );

  zte_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  zte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .perm_shift (perm_shift_r),
    .q_data     (q_data),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

endmodule

// File: rtl/zte_checker.sv
// port-level checks for the z-character text encoder, bound to the top level
// depends on zte_pkg and assert_macros.svh
`include "assert_macros.svh"

module zte_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input zte_pkg::out_t out_data,
  input logic          out_stall
);
  import zte_pkg::*;

  // a stalled output beat stays put
  `ZTE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))
  // end mark sits on the final word and on no other
  `ZTE_ASSERT(a_last_mark, out_valid && out_data.last_word |-> out_data.packed_word[15])
  `ZTE_ASSERT(a_mid_mark, out_valid && !out_data.last_word |-> !out_data.packed_word[15])
  // both sides come out of reset empty and ready
  `ZTE_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_valid && !in_stall)

endmodule

bind zchar_text_encoder zte_checker u_zte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_data  (out_data),
  .out_stall (out_stall)
);

// File: tb/sv/zchar_word_checker.sv
`timescale 1ns / 1ps
// checker for the z-character text encoder: watches the input, result and register
// beats, predicts the packed words and compares them; depends on zte_pkg
module zchar_word_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  zte_pkg::in_t               in_data,
  input  logic                       in_stall,
  input  logic                       out_valid,
  input  zte_pkg::out_t              out_data,
  input  logic                       out_stall,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [zte_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         words_waiting
);
  import zte_pkg::*;

  localparam logic [CFG_AW-1:0] PERM_ADDR = {REG_PERM_SHIFT, 2'b00};

  // predicted state of the encoder
  logic [6:0]  code_tab [256];  // set in [6:5], code in [4:0], zero when unmapped
  logic [1:0]  zset;
  logic [14:0] acc_word;
  logic [1:0]  acc_n;
  logic [7:0]  zc_total;
  logic [4:0]  zc_limit;
  logic        lock_en;

  out_t words_due [$];
  out_t want;

  task automatic wipe_table();
    foreach (code_tab[i]) code_tab[i] = '0;
  endtask

  task automatic stage_zchar(input logic [4:0] z);
    out_t w;
    if (zc_limit != 0 && zc_total >= 8'(zc_limit)) return;
    // a full word is only released once a further z-character turns up
    if (acc_n == PCNT_FULL) begin
      w.packed_word = {1'b0, acc_word};
      w.last_word   = 1'b0;
      words_due.push_back(w);
      acc_word = '0;
      acc_n    = '0;
    end
    acc_word = {acc_word[9:0], z};
    acc_n++;
    if (zc_total != 8'hff) zc_total++;
  endtask

  task automatic encode_char(input logic [7:0] ch, input logic [7:0] nxt);
    logic [6:0] hit;
    logic [6:0] nhit;
    logic [4:0] code;
    logic [1:0] cset;
    if (ch == CHAR_SPACE) begin
      stage_zchar(ZC_SPACE);
      return;
    end
    hit  = (int'(ch) < CHAR_CODES) ? code_tab[ch] : '0;
    code = hit[4:0];
    if (code == 0) begin
      // escape lives in set 2, so get there first unless locked there
      if (zset == 2'd1) begin
        stage_zchar(ZC_SHIFT2);
        zset = 2'd0;
      end
      if (zset == 2'd0) stage_zchar(ZC_SHIFT2);
      stage_zchar(ZC_ESCAPE);
      stage_zchar({2'b00, ch[7:5]});
      stage_zchar(ch[4:0]);
      return;
    end
    cset = hit[6:5];
    if (cset != zset && zset != 2'd0) begin
      // step down out of the locked set
      stage_zchar(ZC_TEMP_BASE + 5'd1 + 5'(2'd2 - zset));
      zset = 2'd0;
    end
    if (cset != zset) begin
      stage_zchar(ZC_TEMP_BASE + 5'(cset));
      nhit = (int'(nxt) < CHAR_CODES) ? code_tab[nxt] : '0;
      if (lock_en && nxt != 0 && nhit[4:0] != 0 && nhit[6:5] == cset) begin
        stage_zchar(ZC_TEMP_BASE + 5'(cset));
        zset = cset;
      end
    end
    stage_zchar(code);
  endtask

  task automatic close_string();
    out_t        w;
    logic [14:0] fill;
    logic [1:0]  n;
    if (zc_limit != 0) begin
      while (zc_total < 8'(zc_limit)) stage_zchar(ZC_SHIFT2);
    end
    fill = acc_word;
    n    = acc_n;
    while (n < PCNT_FULL) begin
      fill = {fill[9:0], ZC_SHIFT2};
      n++;
    end
    w.packed_word = {1'b1, fill};  // top bit marks the end of the string
    w.last_word   = 1'b1;
    words_due.push_back(w);
    acc_word = '0;
    acc_n    = '0;
    zc_total = '0;
    zset     = '0;
  endtask

  task automatic predict_item(input in_t b);
    int p;
    p = int'(b.alphabet_position);
    case (b.cmd)
      CMD_CLEAR: wipe_table();
      CMD_LOAD: begin
        if (b.character != 0 && int'(b.character) < CHAR_CODES && p < ALPHABET_ENTRIES)
          code_tab[b.character] = {2'(p / SET_SIZE), 5'(p % SET_SIZE + int'(ZC_CODE_BASE))};
      end
      CMD_START: begin
        zc_limit = b.required_length;
        zc_total = '0;
        acc_word = '0;
        acc_n    = '0;
        zset     = '0;
      end
      CMD_ENCODE: encode_char(b.character, b.next_character);
      CMD_FINISH: close_string();
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      wipe_table();
      zset       = '0;
      acc_word   = '0;
      acc_n      = '0;
      zc_total   = '0;
      zc_limit   = '0;
      lock_en    = 1'b0;
      fail_count = 0;
      words_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected word %h last %b", $time,
                     out_data.packed_word, out_data.last_word);
        end else begin
          want = words_due.pop_front();
          if (out_data.packed_word !== want.packed_word ||
              out_data.last_word !== want.last_word) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: word mismatch: expected %h last %b, got %h last %b", $time,
                       want.packed_word, want.last_word,
                       out_data.packed_word, out_data.last_word);
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == PERM_ADDR) lock_en = pwdata[0];
      if (in_valid && !in_stall) predict_item(in_data);
    end
    words_waiting = words_due.size();
  end

endmodule

// File: tb/sv/tb_zchar_text_encoder.sv
`timescale 1ns / 1ps
// top of the z-character text encoder bench: clock, reset, stimulus and verdict
// depends on zte_pkg, zchar_text_encoder and zchar_word_checker
module tb_zchar_text_encoder;
  import zte_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 500;
  localparam int PHASES       = 5;

  localparam logic [CFG_AW-1:0] PERM_ADDR    = {REG_PERM_SHIFT, 2'b00};
  localparam logic [2:0]        CMD_SPARE_LO = 3'd5;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  in_t                 in_data;
  logic                in_stall;
  logic                out_valid;
  out_t                out_data;
  logic                out_stall;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int         fail_count;
  int         words_waiting;
  int         items_sent  = 0;
  int         idle_cycles = 0;
  bit         calm        = 1'b0;
  logic [7:0] alpha_pool [$];

  zchar_text_encoder dut (
    .clk, .rst_n, .in_valid, .in_data, .in_stall, .out_valid, .out_data, .out_stall,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  zchar_word_checker word_chk (
    .clk, .rst_n, .in_valid, .in_data, .in_stall, .out_valid, .out_data, .out_stall,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .words_waiting
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one, none at all in a calm stretch
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_t beat_of(input logic [2:0] c, input logic [7:0] ch,
                                  input logic [7:0] nx, input logic [6:0] pos,
                                  input logic [4:0] rlen);
    in_t b;
    b.cmd               = c;
    b.character         = ch;
    b.next_character    = nx;
    b.alphabet_position = pos;
    b.required_length   = rlen;
    return b;
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65 && alpha_pool.size() != 0)
      return alpha_pool[$urandom_range(0, alpha_pool.size() - 1)];
    if (r < 80) return CHAR_SPACE;
    return 8'($urandom_range(0, 255));
  endfunction

  // called just after a rising edge
  task automatic send_beat(input in_t b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    if (b.cmd <= CMD_FINISH) items_sent++;
  endtask

  task automatic write_perm(input logic v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PERM_ADDR;
    pwdata  <= {31'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait for every predicted word, then let no-result items drain from the pipe
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (words_waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_alphabet(input bit wipe);
    int         n;
    int         pos;
    logic [7:0] ch;
    if (wipe) begin
      send_beat(beat_of(CMD_CLEAR, 8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom)));
      alpha_pool.delete();
    end
    n = ($urandom_range(0, 3) == 0) ? ALPHABET_ENTRIES : $urandom_range(4, 30);
    for (int i = 0; i < n; i++) begin
      pos = (n == ALPHABET_ENTRIES) ? i : $urandom_range(0, ALPHABET_ENTRIES - 1);
      ch  = 8'($urandom_range(1, 255));
      // occasional slot or byte that the block must ignore
      if ($urandom_range(0, 19) == 0) pos = $urandom_range(ALPHABET_ENTRIES, 127);
      if ($urandom_range(0, 19) == 0) ch = 8'd0;
      send_beat(beat_of(CMD_LOAD, ch, 8'($urandom), 7'(pos), 5'($urandom)));
      if (ch != 0) alpha_pool.push_back(ch);
    end
  endtask

  task automatic send_string();
    int         len;
    logic [4:0] rlen;
    logic [7:0] text [$];
    logic [7:0] nx;
    calm = ($urandom_range(0, 5) == 0);
    rlen = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(1, 31)) : 5'd0;
    if ($urandom_range(0, 15) != 0)
      send_beat(beat_of(CMD_START, 8'($urandom), 8'($urandom), 7'($urandom), rlen));
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) text.push_back(pick_char());
    for (int i = 0; i < len; i++) begin
      nx = (i + 1 < len) ? text[i + 1] : 8'd0;
      if ($urandom_range(0, 19) == 0) nx = 8'($urandom);
      send_beat(beat_of(CMD_ENCODE, text[i], nx, 7'($urandom), 5'($urandom)));
    end
    if ($urandom_range(0, 15) != 0)
      send_beat(beat_of(CMD_FINISH, 8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom)));
  endtask

  task automatic send_noise();
    in_t b;
    b = beat_of(3'($urandom), 8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
    if (b.cmd == CMD_CLEAR) alpha_pool.delete();
    send_beat(b);
  endtask

  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_zchar_text_encoder failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase_end;
    int r;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_perm(1'b1);

    // directed: one entry at each end of every set, space mapped, ignored loads
    send_beat(beat_of(CMD_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0));
    send_beat(beat_of(CMD_LOAD, "a", 8'h00, 7'd0, 5'd0));
    send_beat(beat_of(CMD_LOAD, "z", 8'h00, 7'd25, 5'd0));
    send_beat(beat_of(CMD_LOAD, "A", 8'h00, 7'd26, 5'd0));
    send_beat(beat_of(CMD_LOAD, "Z", 8'h00, 7'd51, 5'd0));
    send_beat(beat_of(CMD_LOAD, "0", 8'h00, 7'd52, 5'd0));
    send_beat(beat_of(CMD_LOAD, 8'hff, 8'h00, 7'd77, 5'd0));
    send_beat(beat_of(CMD_LOAD, " ", 8'h00, 7'd10, 5'd0));
    send_beat(beat_of(CMD_LOAD, 8'h00, 8'h00, 7'd5, 5'd0));
    send_beat(beat_of(CMD_LOAD, 8'h80, 8'h00, 7'd127, 5'd0));
    send_beat(beat_of(CMD_SPARE_LO, 8'hff, 8'hff, 7'h7f, 5'h1f));
    send_beat(beat_of(CMD_START, 8'h00, 8'h00, 7'd0, 5'd0));
    send_beat(beat_of(CMD_ENCODE, "A", "Z", 7'd0, 5'd0));
    send_beat(beat_of(CMD_ENCODE, "Z", "0", 7'd0, 5'd0));
    send_beat(beat_of(CMD_ENCODE, "0", 8'hff, 7'd0, 5'd0));
    send_beat(beat_of(CMD_ENCODE, "a", " ", 7'd0, 5'd0));
    send_beat(beat_of(CMD_ENCODE, " ", 8'h00, 7'd0, 5'd0));
    send_beat(beat_of(CMD_ENCODE, 8'h00, "~", 7'd0, 5'd0));
    send_beat(beat_of(CMD_ENCODE, "~", "z", 7'd0, 5'd0));
    send_beat(beat_of(CMD_ENCODE, "z", 8'h00, 7'd0, 5'd0));
    send_beat(beat_of(CMD_FINISH, 8'h00, 8'h00, 7'd0, 5'd0));
    send_beat(beat_of(CMD_START, 8'h00, 8'h00, 7'd0, 5'd31));
    send_beat(beat_of(CMD_ENCODE, "A", "A", 7'd0, 5'd0));
    send_beat(beat_of(CMD_FINISH, 8'h00, 8'h00, 7'd0, 5'd0));
    send_beat(beat_of(CMD_START, 8'h00, 8'h00, 7'd0, 5'd2));
    send_beat(beat_of(CMD_ENCODE, "~", 8'h00, 7'd0, 5'd0));
    send_beat(beat_of(CMD_FINISH, 8'h00, 8'h00, 7'd0, 5'd0));

    // random strings, register toggled between phases
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      write_perm(phase[0]);
      phase_end = items_sent + RANDOM_ITEMS / PHASES;
      if (phase == 0 || $urandom_range(0, 2) == 0) load_alphabet(1'b1);
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 19);
        if (r < 16) send_string();
        else if (r < 17) load_alphabet($urandom_range(0, 1));
        else send_noise();
      end
    end
    calm = 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("tb_zchar_text_encoder passed");
    end else begin
      $display("tb_zchar_text_encoder failed");
    end
    $finish;
  end

endmodule
